// ----- src/earc_pkg.sv -----
// -----------------------------------------------------------------------------
// earc_pkg
// Types, codes and constants shared by the Ethernet ARP/UDP receive classifier.
// -----------------------------------------------------------------------------
package earc_pkg;

	localparam int HEADER_BYTES_DEF   = 42;
	localparam int ARP_MIN_LENGTH_DEF = 60;

	localparam int POS_W = 6;
	localparam int LEN_W = POS_W + 1;
	localparam logic [POS_W-1:0] POS_MAX = 6'd63;
	localparam logic [LEN_W-1:0] UDP_MIN_LENGTH = 7'd42;

	localparam logic [15:0] ETYPE_ARP  = 16'h0806;
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ARP_HTYPE_ETH = 16'h0001;
	localparam logic [7:0]  ARP_HLEN = 8'd6;
	localparam logic [7:0]  ARP_PLEN = 8'd4;
	localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
	localparam logic [15:0] ARP_OP_REPLY   = 16'h0002;
	localparam logic [7:0]  IPV4_VER_IHL = 8'h45;
	localparam logic [7:0]  PROTO_UDP    = 8'h11;
	localparam logic [15:0] IP_MIN_TOTAL = 16'd28;
	localparam logic [15:0] UDP_HDR_LEN  = 16'd8;

	localparam logic [1:0] KIND_DROP        = 2'd0;
	localparam logic [1:0] KIND_ARP_REPLY   = 2'd1;
	localparam logic [1:0] KIND_ARP_REQUEST = 2'd2;
	localparam logic [1:0] KIND_UDP         = 2'd3;

	localparam logic [1:0] REG_LOCAL_MAC  = 2'd0;
	localparam logic [1:0] REG_LOCAL_IP   = 2'd1;
	localparam logic [1:0] REG_RESOLVE_IP = 2'd2;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  frame_kind;
		logic        cache_updated;
		logic [47:0] cached_peer_mac;
		logic [47:0] peer_mac;
		logic [31:0] peer_ip;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [15:0] payload_length;
	} desc_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [47:0] value;
	} cfg_word_t;

endpackage

// ----- src/earc_stream_if.sv -----
// -----------------------------------------------------------------------------
// earc_stream_if
// Valid/ready channel carrying one word of a chosen type.
// -----------------------------------------------------------------------------
interface earc_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/earc_cell.sv -----
// -----------------------------------------------------------------------------
// earc_cell
// One header byte slot; a write token passes from slot to slot per byte.
// -----------------------------------------------------------------------------
module earc_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       last,
	input  logic       tok_in,
	input  logic [7:0] frame_byte,
	output logic       tok_out,
	output logic [7:0] hdr_byte
);
	logic       tok_q;
	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (accept) begin
			// The token moves on unless the frame ends here.
			tok_q <= tok_in & ~last;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && tok_in) begin
			byte_q <= frame_byte;
		end
	end

	assign tok_out  = tok_q;
	assign hdr_byte = byte_q;
endmodule

// ----- src/earc_header_chain.sv -----
// -----------------------------------------------------------------------------
// earc_header_chain
// Row of byte cells that captures the leading header bytes of each frame.
// -----------------------------------------------------------------------------
module earc_header_chain #(
	parameter int HEADER_BYTES = earc_pkg::HEADER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       last,
	input  logic       start,
	input  logic [7:0] frame_byte,
	output logic [7:0] hdr [HEADER_BYTES]
);
	logic tok [HEADER_BYTES];

	for (genvar i = 0; i < HEADER_BYTES; i++) begin : g_cell
		logic tok_in;
		if (i == 0) begin : g_head
			assign tok_in = start;
		end else begin : g_body
			assign tok_in = tok[i-1];
		end

		earc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.accept     (accept),
			.last       (last),
			.tok_in     (tok_in),
			.frame_byte (frame_byte),
			.tok_out    (tok[i]),
			.hdr_byte   (hdr[i])
		);
	end
endmodule

// ----- src/earc_classifier.sv -----
// -----------------------------------------------------------------------------
// earc_classifier
// Decodes the captured header into one frame descriptor.
// -----------------------------------------------------------------------------
module earc_classifier #(
	parameter int HEADER_BYTES   = earc_pkg::HEADER_BYTES_DEF,
	parameter int ARP_MIN_LENGTH = earc_pkg::ARP_MIN_LENGTH_DEF
) (
	input  logic [7:0]              hdr [HEADER_BYTES],
	input  logic [earc_pkg::LEN_W-1:0] len,
	input  logic [31:0]             local_ip,
	input  logic [31:0]             resolve_ip,
	input  logic [47:0]             cache,
	output earc_pkg::desc_t         desc,
	output logic                    cache_load
);
	import earc_pkg::*;

	logic [15:0] etype, arp_htype, arp_ptype, arp_op, ip_total, udp_len;
	logic [47:0] arp_smac;
	logic [31:0] arp_sip, arp_tip, ip_src, ip_dst;
	logic [15:0] udp_sport, udp_dport;
	logic        arp_ok, udp_ok;

	assign etype     = {hdr[12], hdr[13]};
	assign arp_htype = {hdr[14], hdr[15]};
	assign arp_ptype = {hdr[16], hdr[17]};
	assign arp_op    = {hdr[20], hdr[21]};
	assign arp_smac  = {hdr[22], hdr[23], hdr[24], hdr[25], hdr[26], hdr[27]};
	assign arp_sip   = {hdr[28], hdr[29], hdr[30], hdr[31]};
	assign arp_tip   = {hdr[38], hdr[39], hdr[40], hdr[41]};
	assign ip_total  = {hdr[16], hdr[17]};
	assign ip_src    = {hdr[26], hdr[27], hdr[28], hdr[29]};
	assign ip_dst    = {hdr[30], hdr[31], hdr[32], hdr[33]};
	assign udp_sport = {hdr[34], hdr[35]};
	assign udp_dport = {hdr[36], hdr[37]};
	assign udp_len   = {hdr[38], hdr[39]};

	assign arp_ok = (etype == ETYPE_ARP) && (len >= LEN_W'(ARP_MIN_LENGTH)) &&
		(len >= UDP_MIN_LENGTH) && (arp_htype == ARP_HTYPE_ETH) &&
		(arp_ptype == ETYPE_IPV4) && (hdr[18] == ARP_HLEN) && (hdr[19] == ARP_PLEN);

	assign udp_ok = (etype == ETYPE_IPV4) && (len >= UDP_MIN_LENGTH) &&
		(hdr[14] == IPV4_VER_IHL) && (ip_total >= IP_MIN_TOTAL) &&
		(hdr[23] == PROTO_UDP) && (ip_dst == local_ip) && (udp_len >= UDP_HDR_LEN);

	always_comb begin
		desc = '0;
		cache_load = 1'b0;
		priority if (arp_ok) begin
			if (arp_op == ARP_OP_REPLY) begin
				desc.frame_kind = KIND_ARP_REPLY;
				desc.peer_mac   = arp_smac;
				desc.peer_ip    = arp_sip;
				cache_load      = (arp_sip == resolve_ip);
			end else if (arp_op == ARP_OP_REQUEST && arp_tip == local_ip) begin
				desc.frame_kind = KIND_ARP_REQUEST;
				desc.peer_mac   = arp_smac;
				desc.peer_ip    = arp_sip;
			end
		end else if (udp_ok) begin
			desc.frame_kind     = KIND_UDP;
			desc.peer_ip        = ip_src;
			desc.source_port    = udp_sport;
			desc.dest_port      = udp_dport;
			desc.payload_length = udp_len - UDP_HDR_LEN;
		end else begin
			desc.frame_kind = KIND_DROP;
		end
		desc.cache_updated   = cache_load;
		desc.cached_peer_mac = cache_load ? arp_smac : cache;
	end
endmodule

// ----- src/eth_arp_udp_rx_classifier_core.sv -----
// The final byte of a frame sets last_s1; its descriptor then loads into the output register.
// Throughput: one byte per cycle while in.ready is high, set by the header cell row.
// Input ready falls only while a finished descriptor waits for the output register to drain.
// Reset clears the byte counter, cell tokens, cached MAC, addresses and valid flags;
// the header cells hold undefined bytes until a frame writes them.
// -----------------------------------------------------------------------------
// eth_arp_udp_rx_classifier_core
// Receive classifier for Ethernet frames carrying ARP or IPv4/UDP.
// -----------------------------------------------------------------------------
module eth_arp_udp_rx_classifier_core #(
	parameter int HEADER_BYTES   = earc_pkg::HEADER_BYTES_DEF,
	parameter int ARP_MIN_LENGTH = earc_pkg::ARP_MIN_LENGTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	earc_stream_if.sink   in,
	earc_stream_if.source out,
	earc_stream_if.sink   cfg
);
	import earc_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic             last_s1;
	logic [LEN_W-1:0] len_s1;
	logic             valid_s2;
	desc_t            desc_s2;
	logic [31:0]      local_ip_q, resolve_ip_q;
	logic [47:0]      cache_q;

	logic       in_acc, in_last, cfg_acc, stall, load, cache_load;
	logic [7:0] hdr [HEADER_BYTES];
	desc_t      desc;

	assign in_acc  = in.valid & in.ready;
	assign in_last = in.data.frame_last;
	assign cfg_acc = cfg.valid & cfg.ready;
	assign stall   = last_s1 & valid_s2 & ~out.ready;
	assign load    = last_s1 & ~stall;

	assign in.ready  = ~stall;
	assign cfg.ready = 1'b1;
	assign out.valid = valid_s2;
	assign out.data  = desc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_acc) begin
			if (in_last) begin
				pos_q <= '0;
			end else if (pos_q != POS_MAX) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	earc_header_chain #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_acc),
		.last       (in_last),
		.start      (pos_q == '0),
		.frame_byte (in.data.frame_byte),
		.hdr        (hdr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_s1 <= 1'b0;
		end else if (in_acc && in_last) begin
			last_s1 <= 1'b1;
		end else if (load) begin
			last_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_last) begin
			len_s1 <= {1'b0, pos_q} + 1'b1;
		end
	end

	earc_classifier #(
		.HEADER_BYTES   (HEADER_BYTES),
		.ARP_MIN_LENGTH (ARP_MIN_LENGTH)
	) u_classifier (
		.hdr        (hdr),
		.len        (len_s1),
		.local_ip   (local_ip_q),
		.resolve_ip (resolve_ip_q),
		.cache      (cache_q),
		.desc       (desc),
		.cache_load (cache_load)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			desc_s2 <= desc;
		end
	end

	// The own MAC address plays no part on the receive side, so a write to it is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q   <= '0;
			resolve_ip_q <= '0;
			cache_q      <= '0;
		end else if (cfg_acc) begin
			unique case (cfg.data.index)
				REG_LOCAL_IP: begin
					local_ip_q <= cfg.data.value[31:0];
				end
				REG_RESOLVE_IP: begin
					resolve_ip_q <= cfg.data.value[31:0];
					cache_q      <= '0;
				end
				default: begin
				end
			endcase
		end else if (load && cache_load) begin
			cache_q <= desc.peer_mac;
		end
	end

`ifndef SYNTH
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in.ready |-> (last_s1 && valid_s2))
		else $error("input held off without a waiting descriptor");

	a_load_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_s2)
		else $error("finished descriptor did not reach the output register");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_last) |=> (pos_q == '0 && last_s1))
		else $error("final byte did not restart the count or raise a descriptor");

	a_update_is_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && desc_s2.cache_updated) |->
		(desc_s2.frame_kind == KIND_ARP_REPLY && desc_s2.cached_peer_mac == desc_s2.peer_mac))
		else $error("cache update reported outside a matching ARP reply");
`endif
endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Testbench for the Ethernet ARP/UDP receive classifier. Frames are built in a
// buffer, sent one byte per word, and each descriptor is checked against a
// predictor that keeps its own copy of the header bytes, byte position, MAC
// cache and registers.
// -----------------------------------------------------------------------------
module tb;

	import earc_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;

	earc_stream_if #(.word_t(in_word_t))  in_if ();
	earc_stream_if #(.word_t(desc_t))     out_if ();
	earc_stream_if #(.word_t(cfg_word_t)) cfg_if ();

	eth_arp_udp_rx_classifier_core i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in    (in_if),
		.out   (out_if),
		.cfg   (cfg_if)
	);

	// Predictor state
	logic [7:0]       rx_header [HEADER_BYTES_DEF];
	logic [POS_W-1:0] rx_pos;
	logic [47:0]      exp_cache;
	logic [47:0]      own_mac;
	logic [31:0]      own_ip;
	logic [31:0]      exp_resolve_ip;
	desc_t            pending_desc [$];

	logic [7:0] frame_buf [$];
	int idle_pct;
	int stall_pct;
	int error_count;
	int mismatch_count;
	int bytes_sent;
	int frames_sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	// Receiver side: ready is redrawn every falling edge.
	initial begin
		out_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic logic [15:0] be16(int off);
		return {rx_header[off], rx_header[off+1]};
	endfunction

	function automatic logic [31:0] be32(int off);
		return {be16(off), be16(off + 2)};
	endfunction

	function automatic logic [47:0] be48(int off);
		return {be16(off), be32(off + 2)};
	endfunction

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Predicts the effect of one accepted frame byte.
	task automatic classify_byte(input logic [7:0] b, input logic last);
		desc_t d;
		logic [LEN_W-1:0] flen;
		logic [15:0] etype;
		if (rx_pos < HEADER_BYTES_DEF)
			rx_header[rx_pos] = b;
		if (!last) begin
			if (rx_pos != POS_MAX)
				rx_pos++;
		end else begin
			flen = {1'b0, rx_pos} + 7'd1;
			rx_pos = '0;
			d = '0;
			etype = be16(12);
			if (etype == ETYPE_ARP && flen >= ARP_MIN_LENGTH_DEF && flen >= UDP_MIN_LENGTH &&
			    be16(14) == ARP_HTYPE_ETH && be16(16) == ETYPE_IPV4 &&
			    rx_header[18] == ARP_HLEN && rx_header[19] == ARP_PLEN) begin
				if (be16(20) == ARP_OP_REPLY) begin
					d.frame_kind = KIND_ARP_REPLY;
					d.peer_mac = be48(22);
					d.peer_ip = be32(28);
					if (be32(28) == exp_resolve_ip) begin
						exp_cache = be48(22);
						d.cache_updated = 1'b1;
					end
				end else if (be16(20) == ARP_OP_REQUEST && be32(38) == own_ip) begin
					d.frame_kind = KIND_ARP_REQUEST;
					d.peer_mac = be48(22);
					d.peer_ip = be32(28);
				end
			end else if (etype == ETYPE_IPV4 && flen >= UDP_MIN_LENGTH &&
			             rx_header[14] == IPV4_VER_IHL && be16(16) >= IP_MIN_TOTAL &&
			             rx_header[23] == PROTO_UDP && be32(30) == own_ip &&
			             be16(38) >= UDP_HDR_LEN) begin
				d.frame_kind = KIND_UDP;
				d.peer_ip = be32(26);
				d.source_port = be16(34);
				d.dest_port = be16(36);
				d.payload_length = be16(38) - UDP_HDR_LEN;
			end
			d.cached_peer_mac = exp_cache;
			pending_desc.push_back(d);
		end
	endtask

	task automatic check_field(input string name, input logic [47:0] want,
	                           input logic [47:0] got);
		if (got !== want) begin
			error_count++;
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch in %s: expected %h, got %h", name, want, got);
		end
	endtask

	// Descriptor checker
	initial begin
		desc_t want;
		desc_t got;
		forever begin
			@(posedge clk);
			if (arst_n && out_if.valid && out_if.ready) begin
				got = out_if.data;
				if (pending_desc.size() == 0) begin
					error_count++;
					$display("descriptor with none expected: %h", got);
				end else begin
					want = pending_desc.pop_front();
					check_field("frame_kind", want.frame_kind, got.frame_kind);
					check_field("cache_updated", want.cache_updated, got.cache_updated);
					check_field("cached_peer_mac", want.cached_peer_mac, got.cached_peer_mac);
					check_field("peer_mac", want.peer_mac, got.peer_mac);
					check_field("peer_ip", want.peer_ip, got.peer_ip);
					check_field("source_port", want.source_port, got.source_port);
					check_field("dest_port", want.dest_port, got.dest_port);
					check_field("payload_length", want.payload_length, got.payload_length);
				end
			end
		end
	end

	// Called at a falling edge; returns at a falling edge with valid still high,
	// so that back-to-back words need no extra assignment.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			in_if.valid <= 1'b0;
			@(negedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.data <= '{frame_byte: b, frame_last: last};
		do
			@(posedge clk);
		while (!in_if.ready);
		classify_byte(b, last);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++)
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		frames_sent++;
	endtask

	task automatic start_frame(input int n);
		frame_buf = {};
		for (int i = 0; i < n; i++)
			frame_buf.push_back(8'($urandom));
	endtask

	task automatic put_bytes(input int off, input logic [47:0] value, input int n);
		for (int k = 0; k < n; k++)
			if (off + k < frame_buf.size())
				frame_buf[off+k] = value[8*(n-1-k) +: 8];
	endtask

	task automatic make_arp(input int n, input logic [15:0] op, input logic [47:0] smac,
	                        input logic [31:0] sip, input logic [31:0] tip);
		start_frame(n);
		put_bytes(12, ETYPE_ARP, 2);
		put_bytes(14, ARP_HTYPE_ETH, 2);
		put_bytes(16, ETYPE_IPV4, 2);
		put_bytes(18, ARP_HLEN, 1);
		put_bytes(19, ARP_PLEN, 1);
		put_bytes(20, op, 2);
		put_bytes(22, smac, 6);
		put_bytes(28, sip, 4);
		put_bytes(38, tip, 4);
	endtask

	task automatic make_udp(input int n, input logic [31:0] sip, input logic [31:0] dip,
	                        input logic [15:0] sport, input logic [15:0] dport,
	                        input logic [15:0] ulen);
		start_frame(n);
		put_bytes(12, ETYPE_IPV4, 2);
		put_bytes(14, IPV4_VER_IHL, 1);
		put_bytes(16, 16'($urandom_range(16'hFFFF, IP_MIN_TOTAL)), 2);
		put_bytes(23, PROTO_UDP, 1);
		put_bytes(26, sip, 4);
		put_bytes(30, dip, 4);
		put_bytes(34, sport, 2);
		put_bytes(36, dport, 2);
		put_bytes(38, ulen, 2);
	endtask

	// Holds the sender off until every descriptor has come back, then lets
	// the output pipeline settle.
	task automatic wait_drained();
		in_if.valid <= 1'b0;
		while (pending_desc.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Leaves valid high; the caller lowers it after its last write.
	task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= '{index: idx, value: value};
		do
			@(posedge clk);
		while (!cfg_if.ready);
		case (idx)
			REG_LOCAL_MAC: own_mac = value;
			REG_LOCAL_IP: own_ip = value[31:0];
			REG_RESOLVE_IP: begin
				exp_resolve_ip = value[31:0];
				exp_cache = '0;
			end
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic reconfigure(input logic [47:0] mac, input logic [47:0] lip,
	                           input logic [47:0] rip, input bit touch_resolve);
		wait_drained();
		write_reg(REG_LOCAL_MAC, mac);
		write_reg(REG_LOCAL_IP, lip);
		if (touch_resolve)
			write_reg(REG_RESOLVE_IP, rip);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic test_registers();
		// Upper bits above 32 are set to show that the address registers mask them.
		wait_drained();
		write_reg(REG_LOCAL_MAC, '1);
		write_reg(REG_LOCAL_IP, 48'hABCD_C0A8_0001);
		write_reg(REG_RESOLVE_IP, 48'hFFFF_C0A8_0002);
		write_reg(REG_UNUSED, rand48());
		cfg_if.valid <= 1'b0;
		// The first frame fills every header byte.
		make_udp(42, 32'h0A00_0001, own_ip, 16'h0000, 16'hFFFF, UDP_HDR_LEN);
		send_frame();
	endtask

	task automatic test_arp();
		logic [47:0] mac_a;
		mac_a = rand48();
		make_arp(60, ARP_OP_REPLY, mac_a, exp_resolve_ip, 32'h0);
		send_frame();
		make_arp(64, ARP_OP_REPLY, '1, exp_resolve_ip ^ 32'h1, own_ip);
		send_frame();
		make_arp(61, ARP_OP_REQUEST, rand48(), 32'hFFFF_FFFF, own_ip);
		send_frame();
		make_arp(60, ARP_OP_REQUEST, rand48(), $urandom, own_ip ^ 32'h8000_0000);
		send_frame();
		make_arp(60, 16'h0003, rand48(), exp_resolve_ip, own_ip);
		send_frame();
		// A well-formed reply one byte too short is dropped.
		make_arp(ARP_MIN_LENGTH_DEF - 1, ARP_OP_REPLY, rand48(), exp_resolve_ip, own_ip);
		send_frame();
		make_arp(60, ARP_OP_REPLY, rand48(), exp_resolve_ip, own_ip);
		put_bytes(14, 16'h0006, 2);
		send_frame();
		make_arp(60, ARP_OP_REPLY, rand48(), exp_resolve_ip, own_ip);
		put_bytes(16, 16'h86DD, 2);
		send_frame();
		make_arp(60, ARP_OP_REPLY, rand48(), exp_resolve_ip, own_ip);
		put_bytes(18, 8'd8, 1);
		send_frame();
		make_arp(60, ARP_OP_REQUEST, rand48(), exp_resolve_ip, own_ip);
		put_bytes(19, 8'd16, 1);
		send_frame();
		// Rewriting the address being resolved empties the cache.
		reconfigure(own_mac, own_ip, 48'h0, 1'b1);
		make_arp(60, 16'h0002, 48'h0, 32'h0, 32'h0);
		put_bytes(12, 16'h0800, 2);
		send_frame();
	endtask

	task automatic test_udp();
		make_udp(42, '1, own_ip, '1, 16'h0000, 16'hFFFF);
		send_frame();
		make_udp(41, $urandom, own_ip, 16'h1234, 16'h5678, 16'd100);
		send_frame();
		make_udp(42, $urandom, own_ip, 16'h1234, 16'h5678, 16'd7);
		send_frame();
		make_udp(42, $urandom, own_ip, 16'h1234, 16'h5678, 16'd20);
		put_bytes(16, 16'd27, 2);
		send_frame();
		make_udp(42, $urandom, own_ip, 16'h1234, 16'h5678, 16'd20);
		put_bytes(16, IP_MIN_TOTAL, 2);
		send_frame();
		make_udp(42, $urandom, own_ip, 16'h1234, 16'h5678, 16'd20);
		put_bytes(14, 8'h46, 1);
		send_frame();
		make_udp(42, $urandom, own_ip, 16'h1234, 16'h5678, 16'd20);
		put_bytes(23, 8'h06, 1);
		send_frame();
		make_udp(42, $urandom, own_ip ^ 32'h1, 16'h1234, 16'h5678, 16'd20);
		send_frame();
		// Longer than the byte counter can tell apart: it counts as 64 bytes.
		make_udp(70, $urandom, own_ip, $urandom, $urandom, $urandom_range(16'hFFFF, 8));
		send_frame();
	endtask

	task automatic test_odd_frames();
		start_frame(1);
		send_frame();
		start_frame(14);
		put_bytes(12, 16'h86DD, 2);
		send_frame();
		// Address registers at their extremes: all zeros, then all ones.
		reconfigure('0, '0, '1, 1'b1);
		make_udp(48, 32'h0, 32'h0, 16'd53, 16'd53, 16'd8);
		send_frame();
		make_arp(60, ARP_OP_REPLY, '1, '1, '0);
		send_frame();
		reconfigure(own_mac, '1, '0, 1'b0);
		make_arp(60, ARP_OP_REQUEST, '0, '0, '1);
		send_frame();
	endtask

	task automatic random_frame();
		int pick;
		int n;
		int flaw;
		logic [15:0] ulen;
		pick = $urandom_range(99);
		flaw = ($urandom_range(99) < 15) ? $urandom_range(3) + 1 : 0;
		if (pick < 35) begin
			n = ($urandom_range(19) == 0) ? $urandom_range(90, 61) : $urandom_range(60, 42);
			case ($urandom_range(3))
				0: ulen = UDP_HDR_LEN;
				1: ulen = '1;
				default: ulen = $urandom_range(16'hFFFF, 8);
			endcase
			make_udp(n, $urandom, ($urandom_range(9) == 0) ? 32'($urandom) : own_ip,
			         $urandom, $urandom, ulen);
			case (flaw)
				1: put_bytes(14, 8'($urandom), 1);
				2: put_bytes(16, 16'($urandom_range(27)), 2);
				3: put_bytes(23, 8'($urandom), 1);
				4: put_bytes(38, 16'($urandom_range(7)), 2);
				default: ;
			endcase
		end else if (pick < 65) begin
			case ($urandom_range(9))
				0: n = $urandom_range(59, 42);
				1: n = $urandom_range(90, 65);
				default: n = $urandom_range(66, 60);
			endcase
			make_arp(n, ($urandom_range(9) == 0) ? 16'($urandom) :
			         ($urandom_range(1) ? ARP_OP_REPLY : ARP_OP_REQUEST),
			         rand48(), $urandom_range(1) ? exp_resolve_ip : 32'($urandom),
			         ($urandom_range(3) == 0) ? 32'($urandom) : own_ip);
			case (flaw)
				1: put_bytes(14, 16'($urandom), 2);
				2: put_bytes(16, 16'($urandom), 2);
				3: put_bytes(18, 8'($urandom), 1);
				4: put_bytes(19, 8'($urandom), 1);
				default: ;
			endcase
		end else begin
			start_frame($urandom_range(1) ? $urandom_range(41, 1) : $urandom_range(70, 42));
		end
		send_frame();
	endtask

	task automatic test_random_phase(input int send_idle, input int recv_stall,
	                                 input int min_bytes, input int min_frames);
		int first_byte;
		int first_frame;
		case ($urandom_range(3))
			0: reconfigure('0, '0, '0, 1'b1);
			1: reconfigure('1, '1, '1, 1'b1);
			default: reconfigure(rand48(), rand48(), rand48(), $urandom_range(1));
		endcase
		idle_pct = send_idle;
		stall_pct = recv_stall;
		first_byte = bytes_sent;
		first_frame = frames_sent;
		while (bytes_sent - first_byte < min_bytes || frames_sent - first_frame < min_frames) begin
			random_frame();
			if ($urandom_range(49) == 0)
				wait_drained();
		end
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.data = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		rx_pos = '0;
		exp_cache = '0;
		own_mac = '0;
		own_ip = '0;
		exp_resolve_ip = '0;
		idle_pct = 28;
		stall_pct = 28;
		error_count = 0;
		mismatch_count = 0;
		bytes_sent = 0;
		frames_sent = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_registers();
		test_arp();
		test_udp();
		test_odd_frames();
		test_random_phase(0, 0, 40, 1);
		test_random_phase(72, 0, 40, 1);
		test_random_phase(0, 72, 40, 1);
		test_random_phase(28, 28, 40, 1);

		in_if.valid <= 1'b0;
		waited = 0;
		while (pending_desc.size() != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (10) @(negedge clk);
		if (pending_desc.size() != 0) begin
			error_count++;
			$display("%0d descriptors never arrived", pending_desc.size());
		end
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/earc_pkg.sv
src/earc_stream_if.sv
src/earc_cell.sv
src/earc_header_chain.sv
src/earc_classifier.sv
src/eth_arp_udp_rx_classifier_core.sv
test/tb.sv
